// File: rtl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// Tagged chunk locator package
// Shared types, codes and constants for the chunk locator.
// ----------------------------------------------------------------------------
package tcl_pkg;

    // Default width of the byte position counter.
    localparam int POSITION_BITS_DEFAULT = 32;

    // Header layout: four tag bytes, then eight size bytes.
    localparam int TAG_BYTES    = 4;
    localparam int HEADER_BYTES = 12;

    // Largest payload size that is accepted.
    localparam logic [30:0] SIZE_LIMIT = 31'h7fff_ffff;

    // Configuration register indexes.
    localparam logic REG_TARGET_TAG = 1'b0;
    localparam logic REG_MISSING    = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MISSING   = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    // Scan phase.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [31:0] payload_offset;
        logic [30:0] chunk_size;
    } t_result;

endpackage

// File: rtl/tcl_parser.sv
// ----------------------------------------------------------------------------
// Chunk header parser
// Walks the chunk region one byte at a time and raises at most one result per region.
// ----------------------------------------------------------------------------
module tcl_parser import tcl_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_region_end,
    input  logic [31:0] i_target_tag,
    input  logic        i_missing_is_error,
    output logic        o_push,
    output t_result     o_result
);

    t_phase                   r_phase, n_phase;
    logic [3:0]               r_hdr_count, n_hdr_count;
    logic [31:0]              r_tag, n_tag;
    logic [30:0]              r_size, n_size;
    logic                     r_ovf, n_ovf;
    logic [30:0]              r_skip, n_skip;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    logic [POSITION_BITS-1:0] next_pos;
    logic [30:0]              skip_dec;
    logic                     hdr_done;
    logic                     too_large;
    logic                     tag_match;

    assign next_pos  = r_pos + POSITION_BITS'(1);
    assign skip_dec  = r_skip - 31'd1;
    assign hdr_done  = (r_phase == PH_HEADER) && (r_hdr_count == 4'(HEADER_BYTES - 1));
    assign too_large = hdr_done && n_ovf;
    assign tag_match = hdr_done && !n_ovf && (n_tag == i_target_tag);

    // Header assembly: tag lanes, low 31 size bits and the overflow flag.
    always_comb begin
        n_tag  = r_tag;
        n_size = r_size;
        n_ovf  = r_ovf;
        case (r_hdr_count)
            4'd0:    n_tag = {24'd0, i_data_byte};
            4'd1:    n_tag = r_tag | {16'd0, i_data_byte, 8'd0};
            4'd2:    n_tag = r_tag | {8'd0, i_data_byte, 16'd0};
            4'd3:    n_tag = r_tag | {i_data_byte, 24'd0};
            4'd4: begin
                n_size = {23'd0, i_data_byte};
                n_ovf  = 1'b0;
            end
            4'd5:    n_size = r_size | {15'd0, i_data_byte, 8'd0};
            4'd6:    n_size = r_size | {7'd0, i_data_byte, 16'd0};
            4'd7: begin
                n_size = r_size | {i_data_byte[6:0], 24'd0};
                n_ovf  = r_ovf | i_data_byte[7];
            end
            default: n_ovf = r_ovf | (i_data_byte != 8'd0);
        endcase
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_region_end) begin
            n_phase = PH_HEADER;
        end else begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (too_large || tag_match) begin
                        n_phase = PH_DONE;
                    end else if (hdr_done && (n_size != 31'd0)) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (skip_dec == 31'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_DONE:  n_phase = PH_DONE;
                default:  n_phase = PH_HEADER;
            endcase
        end
    end

    // Counters and the result of this byte.
    always_comb begin
        n_hdr_count = r_hdr_count;
        n_skip      = r_skip;
        n_pos       = next_pos;
        o_push      = 1'b0;
        o_result    = '{status: ST_FOUND, payload_offset: 32'(next_pos),
                        chunk_size: n_size};
        unique case (r_phase)
            PH_HEADER: begin
                n_hdr_count = hdr_done ? 4'd0 : r_hdr_count + 4'd1;
                if (hdr_done) begin
                    n_skip = n_size;
                end
                if (too_large) begin
                    o_push              = 1'b1;
                    o_result.status     = ST_TOO_LARGE;
                    o_result.chunk_size = SIZE_LIMIT;
                end else if (tag_match) begin
                    o_push = 1'b1;
                end
            end
            PH_SKIP:  n_skip = skip_dec;
            PH_DONE:  n_skip = r_skip;
            default:  n_skip = r_skip;
        endcase
        // End of region: report absence unless a result was already given.
        if (i_region_end) begin
            if (!o_push && (r_phase != PH_DONE)) begin
                o_push   = 1'b1;
                o_result = '{status: (i_missing_is_error ? ST_MISSING : ST_NOT_FOUND),
                             payload_offset: 32'd0, chunk_size: 31'd0};
            end
            n_hdr_count = 4'd0;
            n_skip      = 31'd0;
            n_pos       = '0;
        end
        o_push = o_push && i_accept;
    end

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_count <= 4'd0;
            r_tag       <= 32'd0;
            r_size      <= 31'd0;
            r_ovf       <= 1'b0;
            r_skip      <= 31'd0;
            r_pos       <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_hdr_count <= n_hdr_count;
            r_tag       <= i_region_end ? 32'd0 : n_tag;
            r_size      <= i_region_end ? 31'd0 : n_size;
            r_ovf       <= i_region_end ? 1'b0  : n_ovf;
            r_skip      <= n_skip;
            r_pos       <= n_pos;
        end
    end

endmodule

// File: rtl/tcl_out_skid.sv
// ----------------------------------------------------------------------------
// Result output buffer
// Result register with a skid stage behind it, so input never waits on the
// output stall combinationally.
// ----------------------------------------------------------------------------
module tcl_out_skid import tcl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    load_out;

    assign load_out = !r_out_valid || !i_out_stall;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: rtl/tagged_chunk_locator.sv
// ----------------------------------------------------------------------------
// Tagged chunk locator
// Finds the chunk with a given four-byte tag in a region of chunks.
// ----------------------------------------------------------------------------
// The block takes one byte of the chunk region per clock cycle while
// o_in_stall is low. Each byte updates the header, skip and position
// counters; any result it causes is registered in the result register, or
// in the skid stage while the output side stalls. Results pass through a
// result register and a one-entry skid stage; o_in_stall is raised only
// while both hold results, which can happen only when the output side
// stalls. At most one result is given per region: found, chunk too large, or
// absence on the final byte. Configuration writes are always accepted and
// should be made between regions.
module tagged_chunk_locator import tcl_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_region_end,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_payload_offset,
    output logic [30:0] o_chunk_size,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_target_tag;
    logic        r_missing_is_error;
    logic        accept;
    logic        push;
    logic        full;
    t_result     result;
    t_result     out_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_tag       <= 32'd0;
            r_missing_is_error <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TARGET_TAG: r_target_tag       <= i_cfg_data;
                REG_MISSING:    r_missing_is_error <= i_cfg_data[0];
                default:        r_target_tag       <= r_target_tag;
            endcase
        end
    end

    tcl_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_data_byte        (i_data_byte),
        .i_region_end       (i_region_end),
        .i_target_tag       (r_target_tag),
        .i_missing_is_error (r_missing_is_error),
        .o_push             (push),
        .o_result           (result)
    );

    tcl_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_full      (full),
        .o_valid     (o_out_valid),
        .o_result    (out_result)
    );

    assign o_status         = out_result.status;
    assign o_payload_offset = out_result.payload_offset;
    assign o_chunk_size     = out_result.chunk_size;

endmodule

// File: rtl/tcl_checker.sv
// ----------------------------------------------------------------------------
// Chunk locator port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module tcl_checker import tcl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [31:0] o_payload_offset,
    input logic [30:0] o_chunk_size
);

    // A stalled result holds its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_payload_offset)
            && $stable(o_chunk_size))
        else $error("result changed while stalled");

    // A fresh result always follows an accepted byte on the previous edge.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("result appeared without an input transaction");

    // An absence result carries neither offset nor size.
    a_absence_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NOT_FOUND || o_status == ST_MISSING) |->
            (o_payload_offset == 32'd0) && (o_chunk_size == 31'd0))
        else $error("absence result with non-zero fields");

    // An oversized chunk reports the saturated size.
    a_too_large_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_TOO_LARGE) |-> (o_chunk_size == SIZE_LIMIT))
        else $error("too-large result without saturated size");

endmodule

bind tagged_chunk_locator tcl_checker u_tcl_checker (.*);
